/* hdl/miller_rabin_primality_unit_defines.svh */
// ----------------------------------------------------------------------------
// Miller-Rabin primality unit: assertion macros
// Shared concurrent check wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef MILLER_RABIN_PRIMALITY_UNIT_DEFINES_SVH
`define MILLER_RABIN_PRIMALITY_UNIT_DEFINES_SVH

// property must hold at every edge out of reset
`define MRP_ASSERT(label_, prop_, msg_) \
  label_: assert property (@(posedge clk_i) disable iff (!rst_ni) prop_) else $error(msg_);

// condition must never be seen out of reset
`define MRP_ASSERT_NEVER(label_, cond_, msg_) \
  label_: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond_)) else $error(msg_);

`endif

/* hdl/mrp_pkg.sv */
// ----------------------------------------------------------------------------
// mrp_pkg
// Types and constants shared by the primality unit's front, queue and back.
// ----------------------------------------------------------------------------
package mrp_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  // range limits for the three test methods
  localparam logic [DATA_W-1:0] TRIAL_LIMIT = 32'd1373653;
  localparam logic [DATA_W-1:0] PAIR_LIMIT  = 32'd9080191;

  // trial division bookkeeping fits well below this width
  localparam int unsigned TRIAL_W = 22;

  // witness bases
  localparam int unsigned BASE_W = 7;
  localparam logic [BASE_W-1:0] BASE_PAIR_0   = 7'd31;
  localparam logic [BASE_W-1:0] BASE_PAIR_1   = 7'd73;
  localparam logic [BASE_W-1:0] BASE_TRIPLE_0 = 7'd2;
  localparam logic [BASE_W-1:0] BASE_TRIPLE_1 = 7'd7;
  localparam logic [BASE_W-1:0] BASE_TRIPLE_2 = 7'd61;
  localparam logic [1:0] PAIR_LAST_IDX   = 2'd1;
  localparam logic [1:0] TRIPLE_LAST_IDX = 2'd2;

  // modular multiplier: bits of the multiplier consumed per cycle
  localparam int unsigned MM_BITS  = 2;
  localparam int unsigned MM_STEPS = DATA_W / MM_BITS;
  localparam int unsigned MM_CNT_W = $clog2(MM_STEPS);

  typedef enum logic [1:0] {
    CLS_DONE   = 2'd0,
    CLS_TRIAL  = 2'd1,
    CLS_PAIR   = 2'd2,
    CLS_TRIPLE = 2'd3
  } cls_e;

  typedef struct packed {
    logic [DATA_W-1:0] cand;
    cls_e              cls;
    logic              verdict;  // answer when cls is CLS_DONE
  } q_entry_t;

  function automatic logic [BASE_W-1:0] mr_base(cls_e cls, logic [1:0] idx);
    logic [BASE_W-1:0] b;
    if (cls == CLS_PAIR) begin
      b = (idx == 2'd0) ? BASE_PAIR_0 : BASE_PAIR_1;
    end else begin
      priority if (idx == 2'd0) b = BASE_TRIPLE_0;
      else if (idx == 2'd1)     b = BASE_TRIPLE_1;
      else                      b = BASE_TRIPLE_2;
    end
    return b;
  endfunction

endpackage

/* hdl/miller_rabin_primality_unit.sv */
// Values below 2, even values and multiples of 3 are answered by the front classifier.
// Trial division: up to 195 values of k, each testing 6k - 1 and 6k + 1 in the multiplier.
// Witness rounds: every modular product runs in the shared multiplier, started by the sequencer;
// up to about 63 products a base, for two bases or for three.
// One candidate is worked on at a time; a 2-entry queue takes new ones meanwhile.
// Reset (rst_ni, async, active low) empties queue and result register.
// ----------------------------------------------------------------------------
// miller_rabin_primality_unit
// Deterministic 32-bit primality test: front classifier, queue, sequencer.
// ----------------------------------------------------------------------------
module miller_rabin_primality_unit import mrp_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] candidate_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              is_prime_o
);

  logic     push, full, pop, q_valid;
  q_entry_t push_entry, head_entry;

  mrp_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .candidate_i(candidate_i),
    .push_o     (push),
    .entry_o    (push_entry),
    .full_i     (full)
  );

  mrp_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .entry_o(head_entry)
  );

  mrp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (head_entry),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .is_prime_o (is_prime_o)
  );

endmodule

/* hdl/mrp_front.sv */
// ----------------------------------------------------------------------------
// mrp_front
// Accepts candidates and sorts them: trivial answer, trial division,
// two-base or three-base witness test.
// ----------------------------------------------------------------------------
module mrp_front import mrp_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] candidate_i,
  output logic              push_o,
  output q_entry_t          entry_o,
  input  logic              full_i
);

  logic [4:0]  cnt_even;
  logic [4:0]  cnt_odd;
  logic [5:0]  wsum;
  logic [11:0] prod;
  logic [4:0]  quot;
  logic [5:0]  rem3;

  // 4^i = 1 and 2*4^i = 2 (mod 3)
  always_comb begin
    cnt_even = '0;
    cnt_odd  = '0;
    for (int i = 0; i < DATA_W / 2; i++) begin
      cnt_even = cnt_even + 5'(candidate_i[2*i]);
      cnt_odd  = cnt_odd  + 5'(candidate_i[2*i+1]);
    end
    wsum = 6'(cnt_even) + {cnt_odd, 1'b0};
    prod = 12'(wsum) * 12'd43;  // floor(v/3) for v below 64
    quot = prod[11:7];
    rem3 = wsum - 6'(quot) * 6'd3;
  end

  always_comb begin
    entry_o.cand    = candidate_i;
    entry_o.cls     = CLS_DONE;
    entry_o.verdict = 1'b0;
    priority if (candidate_i < 32'd2) begin
      entry_o.verdict = 1'b0;
    end else if (!candidate_i[0]) begin
      entry_o.verdict = (candidate_i == 32'd2);
    end else if (rem3 == 6'd0) begin
      entry_o.verdict = (candidate_i == 32'd3);
    end else if (candidate_i < TRIAL_LIMIT) begin
      entry_o.cls = CLS_TRIAL;
    end else if (candidate_i < PAIR_LIMIT) begin
      entry_o.cls = CLS_PAIR;
    end else begin
      entry_o.cls = CLS_TRIPLE;
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

/* hdl/mrp_queue.sv */
// ----------------------------------------------------------------------------
// mrp_queue
// Small FIFO of classified candidates between front and back.
// ----------------------------------------------------------------------------
module mrp_queue import mrp_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output q_entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_entry_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

endmodule

/* hdl/mrp_mulmod.sv */
// ----------------------------------------------------------------------------
// mrp_mulmod
// Interleaved shift-add modular multiplier: (x * y) mod m, y < m,
// MM_BITS multiplier bits per cycle, done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module mrp_mulmod import mrp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] x_i,
  input  logic [DATA_W-1:0] y_i,
  input  logic [DATA_W-1:0] m_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [DATA_W-1:0] res_o
);

  logic                busy_q, done_q;
  logic [MM_CNT_W-1:0] cnt_q;
  logic [DATA_W-1:0]   x_q, y_q, m_q, acc_q;
  logic [DATA_W:0]     step_acc;

  always_comb begin
    step_acc = {1'b0, acc_q};
    for (int i = 0; i < MM_BITS; i++) begin
      step_acc = {step_acc[DATA_W-1:0], 1'b0};
      if (step_acc >= {1'b0, m_q}) step_acc = step_acc - {1'b0, m_q};
      if (x_q[DATA_W-1-i]) begin
        step_acc = step_acc + {1'b0, y_q};
        if (step_acc >= {1'b0, m_q}) step_acc = step_acc - {1'b0, m_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
      m_q    <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        x_q    <= x_i;
        y_q    <= y_i;
        m_q    <= m_i;
        acc_q  <= '0;
      end else if (busy_q) begin
        acc_q <= step_acc[DATA_W-1:0];
        x_q   <= x_q << MM_BITS;
        cnt_q <= cnt_q + MM_CNT_W'(1);
        if (cnt_q == MM_CNT_W'(MM_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

/* hdl/mrp_back.sv */
// ----------------------------------------------------------------------------
// mrp_back
// Sequencer that runs trial division or witness rounds on one candidate
// through the shared modular multiplier, and holds the result beat.
// ----------------------------------------------------------------------------
`include "miller_rabin_primality_unit_defines.svh"

module mrp_back import mrp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  q_entry_t q_entry_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output logic     is_prime_o
);

  typedef enum logic [11:0] {
    ST_IDLE       = 12'b0000_0000_0001,
    ST_TDIV_CHECK = 12'b0000_0000_0010,
    ST_TDIV_LO    = 12'b0000_0000_0100,
    ST_TDIV_HI    = 12'b0000_0000_1000,
    ST_MR_SETUP   = 12'b0000_0001_0000,
    ST_MR_TZ      = 12'b0000_0010_0000,
    ST_POW_STEP   = 12'b0000_0100_0000,
    ST_POW_MUL    = 12'b0000_1000_0000,
    ST_POW_SQ     = 12'b0001_0000_0000,
    ST_SQR        = 12'b0010_0000_0000,
    ST_SQR_WAIT   = 12'b0100_0000_0000,
    ST_FINISH     = 12'b1000_0000_0000
  } state_e;

  state_e             state_q, state_d;
  cls_e               cls_q, cls_d;
  logic [DATA_W-1:0]  m_q, m_d;
  logic [DATA_W-1:0]  e_q, e_d;       // odd part d, then exponent
  logic [DATA_W-1:0]  acc_q, acc_d;
  logic [DATA_W-1:0]  sq_q, sq_d;
  logic [4:0]         s_q, s_d;
  logic [4:0]         i_q, i_d;
  logic [1:0]         bidx_q, bidx_d;
  logic [TRIAL_W-1:0] f_q, f_d;       // 36k^2 - 12k
  logic [TRIAL_W-1:0] delta_q, delta_d;
  logic [TRIAL_W-1:0] dlo_q, dlo_d;   // 6k - 1
  logic               res_q, res_d;
  logic               out_valid_q, out_valid_d;
  logic               is_prime_q, is_prime_d;

  logic               mm_start, mm_busy, mm_done;
  logic [DATA_W-1:0]  mm_x, mm_y, mm_m, mm_res;
  logic               last_base, out_load;
  logic [DATA_W-1:0]  m_minus1;

  mrp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .x_i    (mm_x),
    .y_i    (mm_y),
    .m_i    (mm_m),
    .busy_o (mm_busy),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  assign last_base = (cls_q == CLS_PAIR) ? (bidx_q == PAIR_LAST_IDX)
                                         : (bidx_q == TRIPLE_LAST_IDX);
  assign m_minus1  = m_q - 32'd1;
  assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d  = state_q;
    cls_d    = cls_q;
    m_d      = m_q;
    e_d      = e_q;
    acc_d    = acc_q;
    sq_d     = sq_q;
    s_d      = s_q;
    i_d      = i_q;
    bidx_d   = bidx_q;
    f_d      = f_q;
    delta_d  = delta_q;
    dlo_d    = dlo_q;
    res_d    = res_q;
    pop_o    = 1'b0;
    mm_start = 1'b0;
    mm_x     = m_q;
    mm_y     = 32'd1;
    mm_m     = DATA_W'(dlo_q);

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          m_d     = q_entry_i.cand;
          cls_d   = q_entry_i.cls;
          res_d   = q_entry_i.verdict;
          f_d     = TRIAL_W'(24);
          delta_d = TRIAL_W'(96);
          dlo_d   = TRIAL_W'(5);
          bidx_d  = '0;
          unique case (q_entry_i.cls)
            CLS_DONE:             state_d = ST_FINISH;
            CLS_TRIAL:            state_d = ST_TDIV_CHECK;
            CLS_PAIR, CLS_TRIPLE: state_d = ST_MR_SETUP;
            default:              state_d = ST_FINISH;
          endcase
        end
      end
      ST_TDIV_CHECK: begin
        if (DATA_W'(f_q) >= m_q) begin
          res_d   = 1'b1;
          state_d = ST_FINISH;
        end else begin
          mm_start = 1'b1;
          state_d  = ST_TDIV_LO;
        end
      end
      ST_TDIV_LO: begin
        if (mm_done) begin
          if (mm_res == '0) begin
            res_d   = 1'b0;
            state_d = ST_FINISH;
          end else begin
            mm_start = 1'b1;
            mm_m     = DATA_W'(dlo_q) + 32'd2;
            state_d  = ST_TDIV_HI;
          end
        end
      end
      ST_TDIV_HI: begin
        if (mm_done) begin
          if (mm_res == '0) begin
            res_d   = 1'b0;
            state_d = ST_FINISH;
          end else begin
            f_d     = f_q + delta_q;
            delta_d = delta_q + TRIAL_W'(72);
            dlo_d   = dlo_q + TRIAL_W'(6);
            state_d = ST_TDIV_CHECK;
          end
        end
      end
      ST_MR_SETUP: begin
        e_d     = m_q >> 1;
        s_d     = 5'd1;
        acc_d   = 32'd1;
        sq_d    = DATA_W'(mr_base(cls_q, bidx_q));
        state_d = ST_MR_TZ;
      end
      ST_MR_TZ: begin
        if (!e_q[0]) begin
          e_d = e_q >> 1;
          s_d = s_q + 5'd1;
        end else begin
          state_d = ST_POW_STEP;
        end
      end
      ST_POW_STEP: begin
        mm_m = m_q;
        if (e_q == '0) begin
          i_d     = '0;
          state_d = ST_SQR;
        end else if (e_q[0]) begin
          mm_start = 1'b1;
          mm_x     = acc_q;
          mm_y     = sq_q;
          state_d  = ST_POW_MUL;
        end else begin
          mm_start = 1'b1;
          mm_x     = sq_q;
          mm_y     = sq_q;
          state_d  = ST_POW_SQ;
        end
      end
      ST_POW_MUL: begin
        mm_m = m_q;
        mm_x = sq_q;
        mm_y = sq_q;
        if (mm_done) begin
          acc_d    = mm_res;
          mm_start = 1'b1;
          state_d  = ST_POW_SQ;
        end
      end
      ST_POW_SQ: begin
        if (mm_done) begin
          sq_d    = mm_res;
          e_d     = e_q >> 1;
          state_d = ST_POW_STEP;
        end
      end
      // acc holds the running value "prev" from here on
      ST_SQR: begin
        mm_start = 1'b1;
        mm_m     = m_q;
        mm_x     = acc_q;
        mm_y     = acc_q;
        state_d  = ST_SQR_WAIT;
      end
      ST_SQR_WAIT: begin
        if (mm_done) begin
          acc_d = mm_res;
          i_d   = i_q + 5'd1;
          priority if (mm_res == 32'd1 && acc_q != 32'd1 && acc_q != m_minus1) begin
            res_d   = 1'b0;
            state_d = ST_FINISH;
          end else if (i_q + 5'd1 != s_q) begin
            state_d = ST_SQR;
          end else if (mm_res != 32'd1) begin
            res_d   = 1'b0;
            state_d = ST_FINISH;
          end else if (last_base) begin
            res_d   = 1'b1;
            state_d = ST_FINISH;
          end else begin
            bidx_d  = bidx_q + 2'd1;
            state_d = ST_MR_SETUP;
          end
        end
      end
      ST_FINISH: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    is_prime_d  = out_load ? res_q : is_prime_q;
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q      <= cls_d;
    m_q        <= m_d;
    e_q        <= e_d;
    acc_q      <= acc_d;
    sq_q       <= sq_d;
    s_q        <= s_d;
    i_q        <= i_d;
    bidx_q     <= bidx_d;
    f_q        <= f_d;
    delta_q    <= delta_d;
    dlo_q      <= dlo_d;
    res_q      <= res_d;
    is_prime_q <= is_prime_d;
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

  `MRP_ASSERT(a_pop_needs_entry, pop_o |-> q_valid_i, "pop from empty queue")
  `MRP_ASSERT(a_mm_start_idle, mm_start |-> !mm_busy, "multiplier started while busy")
  `MRP_ASSERT(a_out_slot_free, out_load |-> (!out_valid_q || out_ready_i), "result beat overwritten")
  `MRP_ASSERT_NEVER(a_mr_odd_large, (state_q == ST_MR_SETUP) && (!m_q[0] || m_q < TRIAL_LIMIT), "witness test on small or even value")

endmodule

/* test/miller_rabin_primality_unit_test.sv */
// ----------------------------------------------------------------------------
// Primality unit testbench
// Drives 32-bit candidates through the valid/ready input, predicts each verdict
// with a local deterministic prime test and checks every output beat in order.
// ----------------------------------------------------------------------------
module miller_rabin_primality_unit_test import mrp_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 10_000_000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [DATA_W-1:0] candidate_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              is_prime_o;

  logic verdict_q[$];
  int   fail_cnt;
  int   cycle_cnt;
  bit   no_idle;     // long stretch without random gaps
  bit   sink_hold;   // receiver held off by the pressure test

  miller_rabin_primality_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .candidate_i(candidate_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .is_prime_o (is_prime_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---- predictor ----------------------------------------------------------
  function automatic logic [31:0] mulmod(logic [31:0] a, logic [31:0] b, logic [31:0] m);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return 32'(p % {32'd0, m});
  endfunction

  function automatic logic [31:0] powmod(logic [31:0] b, logic [31:0] e, logic [31:0] m);
    logic [31:0] acc;
    logic [31:0] sq;
    acc = 32'd1 % m;
    sq  = b % m;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, sq, m);
      sq = mulmod(sq, sq, m);
      e  = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit witness_composite(logic [31:0] b, logic [31:0] m);
    logic [31:0] d;
    logic [31:0] prv;
    logic [31:0] cur;
    int          s;
    d = m >> 1;
    s = 1;
    cur = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    prv = powmod(b, d, m);
    for (int i = 0; i < s; i++) begin
      cur = mulmod(prv, prv, m);
      if (cur == 1 && prv != 1 && prv != m - 1) return 1'b1;
      prv = cur;
    end
    return cur != 1;
  endfunction

  function automatic logic prime_verdict(logic [31:0] m);
    longint unsigned k;
    if (m < 2) return 1'b0;
    if (!m[0]) return m == 2;
    if (m % 3 == 0) return m == 3;
    if (m < TRIAL_LIMIT) begin
      for (k = 1; 36 * k * k - 12 * k < m; k++) begin
        if (m % (6 * k + 1) == 0 || m % (6 * k - 1) == 0) return 1'b0;
      end
      return 1'b1;
    end
    if (m < PAIR_LIMIT)
      return !(witness_composite(32'd31, m) || witness_composite(32'd73, m));
    return !(witness_composite(32'd2, m) || witness_composite(32'd7, m) ||
             witness_composite(32'd61, m));
  endfunction

  // ---- driving ------------------------------------------------------------
  // valid is left high after the beat; a gap in the next call or a drain drops it
  task automatic send_candidate(logic [31:0] c);
    while (!no_idle && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    candidate_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    verdict_q.insert(verdict_q.size(), prime_verdict(c));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
  endtask

  // receiver: random stalls, decided at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= !sink_hold && (no_idle || $urandom_range(99) >= 28);
  end

  // checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual is_prime=%0b",
                 $realtime, is_prime_o);
        fail_cnt++;
      end else begin
        logic exp_v;
        exp_v = verdict_q.pop_front();
        if (is_prime_o !== exp_v) begin
          $display("%0t: is_prime mismatch, expected %0b, actual %0b",
                   $realtime, exp_v, is_prime_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("miller_rabin_primality_unit verification failed");
      $finish;
    end
  end

  // ---- tests --------------------------------------------------------------
  task automatic test_directed();
    logic [31:0] vals[$];
    vals = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
             32'd1373651, 32'd1373653, 32'd1373639, 32'd9080189, 32'd9080191,
             32'd9080197, 32'd2147483647, 32'd4294967291, 32'd4294967295,
             32'd4294967294, 32'd3215031751, 32'd25326001, 32'h5555_5555,
             32'hAAAA_AAAB, 32'd65521};
    foreach (vals[i]) send_candidate(vals[i]);
  endtask

  function automatic logic [31:0] rand_candidate();
    case ($urandom_range(3))
      0:       return $urandom_range(1373652);
      1:       return $urandom_range(9080190, 1373653);
      2:       return $urandom;
      default: return $urandom | 32'd1;
    endcase
  endfunction

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      no_idle = (i >= n / 2 && i < n / 2 + 40);
      send_candidate(rand_candidate());
    end
    no_idle = 1'b0;
  endtask

  // receiver held off while the sender keeps offering, so the queue fills
  task automatic test_backpressure();
    fork
      begin
        sink_hold = 1'b1;
        repeat (3000) @(negedge clk_i);
        sink_hold = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_candidate($urandom_range(9080190, 1373653) | 32'd1);
    join
    wait_drained();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    candidate_i = '0;
    out_ready_i = 1'b0;
    fail_cnt    = 0;
    cycle_cnt   = 0;
    no_idle     = 1'b0;
    sink_hold   = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    wait_drained();   // sender pause until all verdicts are back
    test_backpressure();
    test_random(270);
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0) $display("miller_rabin_primality_unit verification clean");
    else $display("miller_rabin_primality_unit verification failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/mrp_pkg.sv
hdl/mrp_front.sv
hdl/mrp_queue.sv
hdl/mrp_mulmod.sv
hdl/mrp_back.sv
hdl/miller_rabin_primality_unit.sv
test/miller_rabin_primality_unit_test.sv
